// ----- rtl/tfn_pkg.sv -----
// Package for the triangle face normal unit.
// Holds the payload structs, the queue entry and search stage types and the widths.
// No dependencies.
package tfn_pkg;

    // Field and datapath widths.
    localparam int CoordW     = 16;
    localparam int EdgeW      = 17;
    localparam int ProdW      = 34;
    localparam int HalfW      = 17;
    localparam int SqW        = 66;
    localparam int LenW       = 68;
    localparam int KW         = 15;
    localparam int ScaleShift = 30;
    localparam int CmpW       = 102;
    localparam int NormW      = 16;

    // Default depth of the queue between the front and back parts.
    localparam int QueueDepth = 4;

    // One triangle as it enters.
    typedef struct packed {
        logic signed [CoordW-1:0] a_x;
        logic signed [CoordW-1:0] a_y;
        logic signed [CoordW-1:0] a_z;
        logic signed [CoordW-1:0] b_x;
        logic signed [CoordW-1:0] b_y;
        logic signed [CoordW-1:0] b_z;
        logic signed [CoordW-1:0] c_x;
        logic signed [CoordW-1:0] c_y;
        logic signed [CoordW-1:0] c_z;
    } tri_in_t;

    // One unit normal as it leaves.
    typedef struct packed {
        logic signed [NormW-1:0] unit_x;
        logic signed [NormW-1:0] unit_y;
        logic signed [NormW-1:0] unit_z;
        logic                    degenerate;
    } normal_out_t;

    // Classified face handed from the front part to the back part.
    typedef struct packed {
        logic [2:0]               neg;
        logic [2:0][SqW-1:0]      sq;
        logic [LenW-1:0]          len2;
        logic                     degenerate;
    } face_t;

    // State of the bitwise rounding search for all three components.
    // p holds (2k-1)^2 * len2, q holds (2k-1) * len2 in two's complement.
    typedef struct packed {
        logic [2:0]               neg;
        logic                     degenerate;
        logic [CmpW-1:0]          len2;
        logic [2:0][CmpW-1:0]     bound;
        logic [2:0][CmpW-1:0]     p;
        logic [2:0][CmpW-1:0]     q;
        logic [2:0][KW-1:0]       k;
    } search_t;

endpackage

// ----- rtl/tfn_front.sv -----
// Front part of the triangle face normal unit: edges, cross product, squared lengths.
// Classifies each face as degenerate or not and pushes it into the queue.
// Depends on tfn_pkg.
module tfn_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tfn_pkg::tri_in_t  s_data,
    output logic              push,
    output tfn_pkg::face_t    push_data,
    input  logic              full
);

    localparam int EdgeW = tfn_pkg::EdgeW;
    localparam int ProdW = tfn_pkg::ProdW;
    localparam int HalfW = tfn_pkg::HalfW;
    localparam int SqW   = tfn_pkg::SqW;
    localparam int LenW  = tfn_pkg::LenW;

    logic [6:1] fv_reg;
    logic       en;

    logic signed [EdgeW-1:0] e0_reg [0:2];
    logic signed [EdgeW-1:0] e1_reg [0:2];
    logic signed [ProdW-1:0] pa_reg [0:2];
    logic signed [ProdW-1:0] pb_reg [0:2];
    logic signed [ProdW-1:0] n_reg  [0:2];
    logic [ProdW-1:0]        mag    [0:2];
    logic [ProdW-1:0]        pll_reg [0:2];
    logic [ProdW-1:0]        phl_reg [0:2];
    logic [ProdW-1:0]        phh_reg [0:2];
    logic [2:0]              neg4_reg, neg5_reg;
    logic                    zero4_reg, zero5_reg;
    logic [SqW-1:0]          sq_reg [0:2];
    tfn_pkg::face_t          face_reg;

    // The whole front advances unless its last word is stuck on a full queue.
    assign en        = !fv_reg[6] || !full;
    assign s_ready   = en;
    assign push      = fv_reg[6] && !full;
    assign push_data = face_reg;

    // Valid bits of the front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (en) begin
            fv_reg <= {fv_reg[5:1], s_valid};
        end
    end

    // Magnitudes of the cross product components.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = n_reg[i][ProdW-1] ? ProdW'(-n_reg[i]) : ProdW'(n_reg[i]);
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            // Edges b - a and c - a.
            e0_reg[0] <= EdgeW'(s_data.b_x) - EdgeW'(s_data.a_x);
            e0_reg[1] <= EdgeW'(s_data.b_y) - EdgeW'(s_data.a_y);
            e0_reg[2] <= EdgeW'(s_data.b_z) - EdgeW'(s_data.a_z);
            e1_reg[0] <= EdgeW'(s_data.c_x) - EdgeW'(s_data.a_x);
            e1_reg[1] <= EdgeW'(s_data.c_y) - EdgeW'(s_data.a_y);
            e1_reg[2] <= EdgeW'(s_data.c_z) - EdgeW'(s_data.a_z);
            // Cross product partial products.
            pa_reg[0] <= ProdW'(e0_reg[1]) * ProdW'(e1_reg[2]);
            pb_reg[0] <= ProdW'(e0_reg[2]) * ProdW'(e1_reg[1]);
            pa_reg[1] <= ProdW'(e0_reg[2]) * ProdW'(e1_reg[0]);
            pb_reg[1] <= ProdW'(e0_reg[0]) * ProdW'(e1_reg[2]);
            pa_reg[2] <= ProdW'(e0_reg[0]) * ProdW'(e1_reg[1]);
            pb_reg[2] <= ProdW'(e0_reg[1]) * ProdW'(e1_reg[0]);
            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= pa_reg[i] - pb_reg[i];
                // Square each magnitude from 17-bit halves.
                pll_reg[i] <= ProdW'(mag[i][HalfW-1:0]) * ProdW'(mag[i][HalfW-1:0]);
                phl_reg[i] <= ProdW'(mag[i][ProdW-1:HalfW]) * ProdW'(mag[i][HalfW-1:0]);
                phh_reg[i] <= ProdW'(mag[i][ProdW-1:HalfW]) * ProdW'(mag[i][ProdW-1:HalfW]);
                sq_reg[i]  <= (SqW'(phh_reg[i]) << (2 * HalfW))
                            + (SqW'(phl_reg[i]) << (HalfW + 1))
                            + SqW'(pll_reg[i]);
                neg4_reg[i] <= n_reg[i][ProdW-1];
            end
            zero4_reg <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            // Squared length and classification.
            face_reg.len2       <= LenW'(sq_reg[0]) + LenW'(sq_reg[1]) + LenW'(sq_reg[2]);
            face_reg.sq[0]      <= sq_reg[0];
            face_reg.sq[1]      <= sq_reg[1];
            face_reg.sq[2]      <= sq_reg[2];
            face_reg.neg        <= neg5_reg;
            face_reg.degenerate <= zero5_reg;
        end
    end

endmodule

// ----- rtl/tfn_queue.sv -----
// Short queue between the front and back parts of the triangle face normal unit.
// Memory with a registered head word. Depends on tfn_pkg.
module tfn_queue #(
    parameter int DEPTH = tfn_pkg::QueueDepth
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tfn_pkg::face_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            out_valid,
    output tfn_pkg::face_t  out_data
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    tfn_pkg::face_t  mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;
    logic            ov_reg;
    tfn_pkg::face_t  head_reg;
    logic            load;

    // Refill the head word whenever it is empty or being taken.
    assign load      = (cnt_reg != '0) && (!ov_reg || pop);
    assign full      = cnt_reg == CntW'(DEPTH);
    assign out_valid = ov_reg;
    assign out_data  = head_reg;

    // Pointers, fill count and head valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (load) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CntW'(push) - CntW'(load);
            if (load) begin
                ov_reg <= 1'b1;
            end else if (pop) begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Storage write and registered read.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (load) begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

// ----- rtl/tfn_back.sv -----
// Back part of the triangle face normal unit: rounding search and output register.
// One pipeline stage per result bit, exact integer compares. Depends on tfn_pkg.
module tfn_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  pop,
    input  tfn_pkg::face_t        in_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tfn_pkg::normal_out_t  m_data
);

    localparam int KW    = tfn_pkg::KW;
    localparam int CmpW  = tfn_pkg::CmpW;
    localparam int NormW = tfn_pkg::NormW;

    tfn_pkg::search_t     stage_reg [0:KW];
    tfn_pkg::search_t     stage_next [1:KW];
    logic [KW:0]          sv_reg;
    logic                 mv_reg;
    tfn_pkg::normal_out_t out_reg;
    logic                 en;
    logic [2:0][NormW-1:0] comp;

    // The back part moves whenever the output word is free or being taken.
    assign en      = !mv_reg || m_ready;
    assign pop     = en && in_valid;
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= '0;
            mv_reg <= 1'b0;
        end else if (en) begin
            sv_reg <= {sv_reg[KW-1:0], in_valid};
            mv_reg <= sv_reg[KW];
        end
    end

    // Start of the search: k = 0, so 2k-1 = -1.
    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg[0].neg        <= in_data.neg;
            stage_reg[0].degenerate <= in_data.degenerate;
            stage_reg[0].len2       <= CmpW'(in_data.len2);
            for (int i = 0; i < 3; i++) begin
                stage_reg[0].bound[i] <= CmpW'(in_data.sq[i]) << tfn_pkg::ScaleShift;
                stage_reg[0].p[i]     <= CmpW'(in_data.len2);
                stage_reg[0].q[i]     <= ~CmpW'(in_data.len2) + 1'b1;
                stage_reg[0].k[i]     <= '0;
            end
        end
    end

    // One stage per bit of k, most significant first.
    for (genvar s = 0; s < KW; s++) begin : g_step
        localparam int Bit = KW - 1 - s;
        logic [2:0][CmpW-1:0] trial;

        always_comb begin
            stage_next[s+1] = stage_reg[s];
            for (int i = 0; i < 3; i++) begin
                trial[i] = stage_reg[s].p[i] + (stage_reg[s].q[i] << (Bit + 2))
                         + (stage_reg[s].len2 << (2 * Bit + 2));
                if (trial[i] <= stage_reg[s].bound[i]) begin
                    stage_next[s+1].p[i] = trial[i];
                    stage_next[s+1].q[i] = stage_reg[s].q[i] + (stage_reg[s].len2 << (Bit + 1));
                    stage_next[s+1].k[i] = stage_reg[s].k[i] | (KW'(1) << Bit);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[s+1] <= stage_next[s+1];
            end
        end
    end

    // Apply signs and force zero on a degenerate face.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (stage_reg[KW].degenerate) begin
                comp[i] = '0;
            end else if (stage_reg[KW].neg[i]) begin
                comp[i] = -NormW'(stage_reg[KW].k[i]);
            end else begin
                comp[i] = NormW'(stage_reg[KW].k[i]);
            end
        end
    end

    // Output word.
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.unit_x     <= comp[0];
            out_reg.unit_y     <= comp[1];
            out_reg.unit_z     <= comp[2];
            out_reg.degenerate <= stage_reg[KW].degenerate;
        end
    end

endmodule

// ----- rtl/triangle_face_normal_unit.sv -----
// Triangle face normal unit, top level.
// Uses tfn_pkg, tfn_front, tfn_queue and tfn_back.
//
// The s_ channel takes one triangle per word: three vertices with signed 16-bit
// coordinates. The m_ channel gives one word per triangle: the unit normal of
// (b - a) x (c - a) in Q1.14, each component rounded to nearest with ties away
// from zero, and a degenerate flag that is set, with a zero normal, when the
// cross product is zero. Words leave in the order they arrive.
// Throughput is one triangle per cycle while the receiver keeps up. From acceptance,
// a result passes six front stages (edges, products, cross product, half squares,
// squares, squared length), the queue memory and its head register, one setup
// stage, fifteen rounding stages (one per result bit) and the output register.
// When the receiver stalls, the back part holds and the queue fills; s_ready
// falls only once the queue is full and the front's last stage is occupied.
// Reset (aresetn low at a clock edge) empties every stage and the queue; no
// clearing pass is needed and a triangle can be taken right after reset.
module triangle_face_normal_unit #(
    parameter int QUEUE_DEPTH = tfn_pkg::QueueDepth
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tfn_pkg::tri_in_t      s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tfn_pkg::normal_out_t  m_data
);

    logic           push, full, pop, q_valid;
    tfn_pkg::face_t push_data, q_data;

    // Edges, cross product and classification.
    tfn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Decoupling queue.
    tfn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    // Normalization and result word.
    tfn_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .pop      (pop),
        .in_data  (q_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for triangle_face_normal_unit.
// Streams directed and random triangles through the s_ channel with random idling on both sides,
// predicts each unit normal with wide integer math, and checks every m_ word. Uses tfn_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    tfn_pkg::tri_in_t     s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    tfn_pkg::normal_out_t m_data;

    tfn_pkg::tri_in_t     pending_tris[$];
    tfn_pkg::normal_out_t expected_normals[$];
    bit                   steady = 1'b0;
    int                   errors = 0;
    int                   normals_checked = 0;
    int                   degenerate_seen = 0;

    triangle_face_normal_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Largest k in 0..16384 with (2k-1)^2 * len2 <= c^2 * 2^30, signed by c.
    function automatic logic [15:0] unit_component(longint c, logic [127:0] len2);
        logic [127:0] mag;
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] odd;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        mag = (c < 0) ? 128'(-c) : 128'(c);
        rhs = (mag * mag) << tfn_pkg::ScaleShift;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 128'(2 * mid - 1);
            lhs = len2 * odd * odd;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return (c < 0) ? 16'(-int'(lo)) : 16'(lo);
    endfunction

    // Unit normal of (b - a) x (c - a) in Q1.14.
    function automatic tfn_pkg::normal_out_t face_normal(tfn_pkg::tri_in_t t);
        longint               e0x, e0y, e0z, e1x, e1y, e1z;
        longint               nx, ny, nz;
        logic [127:0]         len2;
        tfn_pkg::normal_out_t r;
        e0x = longint'(t.b_x) - longint'(t.a_x);
        e0y = longint'(t.b_y) - longint'(t.a_y);
        e0z = longint'(t.b_z) - longint'(t.a_z);
        e1x = longint'(t.c_x) - longint'(t.a_x);
        e1y = longint'(t.c_y) - longint'(t.a_y);
        e1z = longint'(t.c_z) - longint'(t.a_z);
        nx = e0y * e1z - e0z * e1y;
        ny = e0z * e1x - e0x * e1z;
        nz = e0x * e1y - e0y * e1x;
        r = '0;
        if (nx == 0 && ny == 0 && nz == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        // Squares reach 66 bits, so they are formed at full width.
        len2 = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
        r.unit_x = unit_component(nx, len2);
        r.unit_y = unit_component(ny, len2);
        r.unit_z = unit_component(nz, len2);
        return r;
    endfunction

    function automatic tfn_pkg::tri_in_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                                  int cx, int cy, int cz);
        tfn_pkg::tri_in_t t;
        t.a_x = 16'(ax); t.a_y = 16'(ay); t.a_z = 16'(az);
        t.b_x = 16'(bx); t.b_y = 16'(by); t.b_z = 16'(bz);
        t.c_x = 16'(cx); t.c_y = 16'(cy); t.c_z = 16'(cz);
        return t;
    endfunction

    function automatic tfn_pkg::tri_in_t random_tri(int span);
        tfn_pkg::tri_in_t t;
        int               ax, ay, az, dx, dy, dz, s;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // Full range: every coordinate bit toggles.
            t = tfn_pkg::tri_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        end else if (pick < 85) begin
            t = make_tri($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                         $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                         $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                         $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                         $urandom_range(0, 2 * span) - span);
        end else begin
            // Collinear or coincident vertices.
            ax = $urandom_range(0, 2000) - 1000;
            ay = $urandom_range(0, 2000) - 1000;
            az = $urandom_range(0, 2000) - 1000;
            dx = $urandom_range(0, 200) - 100;
            dy = $urandom_range(0, 200) - 100;
            dz = $urandom_range(0, 200) - 100;
            s  = $urandom_range(0, 40) - 20;
            t = make_tri(ax, ay, az, ax + dx, ay + dy, az + dz,
                         ax + s * dx, ay + s * dy, az + s * dz);
        end
        return t;
    endfunction

    // Driver: presents the next pending word, predicting each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_normals.push_back(face_normal(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pending_tris.size() > 0 && (steady || $urandom_range(0, 99) >= 9)) begin
                    s_data  <= pending_tris.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stalls at random except during the steady stretch.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= steady || ($urandom_range(0, 99) >= 9);
    end

    // Monitor: compares each accepted word with the oldest prediction.
    always @(posedge aclk) begin
        tfn_pkg::normal_out_t exp_n;
        if (aresetn && m_valid && m_ready) begin
            if (expected_normals.size() == 0) begin
                $error("unexpected result word %p", m_data);
                errors++;
            end else begin
                exp_n = expected_normals.pop_front();
                normals_checked++;
                if (exp_n.degenerate) degenerate_seen++;
                if (m_data.unit_x !== exp_n.unit_x) begin
                    $error("unit_x expected %0d got %0d", exp_n.unit_x, m_data.unit_x);
                    errors++;
                end
                if (m_data.unit_y !== exp_n.unit_y) begin
                    $error("unit_y expected %0d got %0d", exp_n.unit_y, m_data.unit_y);
                    errors++;
                end
                if (m_data.unit_z !== exp_n.unit_z) begin
                    $error("unit_z expected %0d got %0d", exp_n.unit_z, m_data.unit_z);
                    errors++;
                end
                if (m_data.degenerate !== exp_n.degenerate) begin
                    $error("degenerate expected %0b got %0b", exp_n.degenerate,
                           m_data.degenerate);
                    errors++;
                end
            end
        end
    end

    // Waits until every queued word is accepted and every prediction has been met.
    task automatic drain();
        while (pending_tris.size() > 0 || s_valid || expected_normals.size() > 0)
            @(posedge aclk);
    endtask

    // Stimulus: directed triangles, then random ones with a steady stretch in the middle.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Degenerate: all zero, coincident extremes, collinear.
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_tris.push_back(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                                        -32768, -32768, -32768));
        pending_tris.push_back(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
        pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                        0, 0, 0));
        // Axis-aligned faces give exact unit components of both signs.
        pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
        pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
        // Largest edges and cross products.
        pending_tris.push_back(make_tri(-32768, -32768, 0, 32767, -32768, 0,
                                        -32768, 32767, 0));
        pending_tris.push_back(make_tri(32767, 32767, 32767, -32768, 32767, -32768,
                                        32767, -32768, -32768));
        pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, 32767,
                                        -32768, 32767, 32767));
        pending_tris.push_back(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                                        32767, 32767, -32768));
        // Diagonal and tiny faces.
        pending_tris.push_back(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
        pending_tris.push_back(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 1));
        pending_tris.push_back(make_tri(-1, -1, -1, 0, -1, -1, -1, 0, -1));
        pending_tris.push_back(make_tri(0, 0, 0, 32767, 1, 0, 0, 1, 32767));
        pending_tris.push_back(make_tri(-32768, 0, 0, 32767, 0, 1, -32768, 1, 0));

        // The sender holds off until the pipeline is empty.
        drain();

        for (int i = 0; i < 600; i++) begin
            if (i == 250) begin
                drain();
                steady = 1'b1;
            end
            if (i == 350) begin
                drain();
                steady = 1'b0;
            end
            pending_tris.push_back(random_tri((i % 3 == 0) ? 50 : 32767));
        end

        drain();
        repeat (40) @(posedge aclk);
        $display("Checked %0d unit normals, %0d of them degenerate, from directed and random",
                 normals_checked, degenerate_seen);
        $display("triangles with random idling on both channels and one steady stretch.");
        if (errors == 0 && expected_normals.size() == 0) begin
            $display("triangle_face_normal_unit: match");
        end else begin
            $display("triangle_face_normal_unit: mismatch");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("triangle_face_normal_unit: mismatch");
        $finish;
    end
endmodule
